// File: rtl/core/lbs_pkg.sv
package lbs_pkg;

    // Palette layout: 4 rows of 3 columns per bone
    localparam int WORDS_PER_BONE = 12;
    localparam int MAX_INFL       = 4;
    localparam int BONE_SEL_W     = 6;
    localparam int BONE_W         = 8;
    localparam int WORD_W         = 4;
    localparam int ADDR_W         = 10;
    localparam int WEIGHT_W       = 17;
    localparam int COORD_W        = 32;
    localparam int FRAC_W         = 16;
    localparam int LANE_STAGES    = 5;

    // Divide-by-12 of a palette address: (addr * 683) >> 13 is exact below 1024
    localparam logic [ADDR_W-1:0] RECIP_12    = 10'd683;
    localparam int                RECIP_SHIFT = 13;

    // Request kinds carried on s_axis_tuser
    localparam logic REQ_VERTEX = 1'b1;

    // Input tdata layout, lowest bit first
    localparam int POS_X_LSB    = 0;
    localparam int POS_Y_LSB    = 32;
    localparam int POS_Z_LSB    = 64;
    localparam int BONE_SET_LSB = 96;
    localparam int WEIGHT_LSB   = 120;
    localparam int ADDR_LSB     = 188;
    localparam int VALUE_LSB    = 198;
    localparam int IN_TDATA_W   = 232;
    localparam int OUT_TDATA_W  = 96;

    // Product of a transformed coordinate and a weight
    localparam int TERM_W = COORD_W + WEIGHT_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic signed [TERM_W-1:0]  term_t;

    // Palette write port and stage load enables shared by all lanes
    typedef struct packed {
        logic                   wr_en;
        logic [BONE_W-1:0]      wr_bone;
        logic [WORD_W-1:0]      wr_word;
        coord_t                 wr_data;
        logic [LANE_STAGES-1:0] ld;
    } lbs_ctrl_t;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    // Clamp a signed value to signed 32 bits
    function automatic coord_t sat32(input logic signed [63:0] v);
        coord_t r;
        if (v > SAT_MAX)
        begin
            r = coord_t'(SAT_MAX[COORD_W-1:0]);
        end
        else if (v < SAT_MIN)
        begin
            r = coord_t'(SAT_MIN[COORD_W-1:0]);
        end
        else
        begin
            r = coord_t'(v[COORD_W-1:0]);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/linear_blend_vertex_skinning_top.sv
// A vertex beat accepted on s_axis is shown on m_axis after passing every stage;
// palette write beats produce no output beat. Throughput: one beat per cycle
// unless m_axis_tready stalls the eight-stage pipeline; each influence lane
// holds its own palette copy and nine 32x32 multipliers.
// Reset clears the stage valid bits only; the bone palette is not cleared.
module linear_blend_vertex_skinning_top #(
    parameter int NUM_BONES  = 64,
    parameter int INFLUENCES = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x, pos_y, pos_z, bone_set, weight_0..weight_3, palette_address,
    // palette_value, 2 zero pad bits
    input  logic [lbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x, out_y, out_z
    output logic [lbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lbs_pkg::*;

    localparam int LANES         = (INFLUENCES < MAX_INFL) ? INFLUENCES : MAX_INFL;
    localparam int PALETTE_WORDS = NUM_BONES * WORDS_PER_BONE;
    localparam int NSTAGE        = 8;
    localparam int PAL_CMP_W     = 12;
    localparam int RECIP_PROD_W  = 2 * ADDR_W;
    localparam int ACC_W         = TERM_W + 2;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   go;

    // Address decode of a palette write
    logic [ADDR_W-1:0]       addr_in;
    logic [RECIP_PROD_W-1:0] recip_prod;
    logic [BONE_W-1:0]       dec_bone;
    logic [ADDR_W-1:0]       addr_rem;
    logic                    dec_ok;

    // Stage 0
    logic                    vtx0_reg;
    coord_t                  pos0_reg [3];
    logic [LANES*BONE_SEL_W-1:0] bones0_reg;
    weight_t                 w0_reg [LANES];
    logic [BONE_W-1:0]       wr_bone0_reg;
    logic [WORD_W-1:0]       wr_word0_reg;
    logic                    wr_ok0_reg;
    coord_t                  wr_data0_reg;

    // Stage 1
    coord_t                  pos1_reg [3];

    lbs_ctrl_t               ctrl;
    term_t                   term_w [LANES][3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    coord_t                  out_reg [3];

    // Stall chain: a stage loads when it is empty or its successor loads
    always_comb
    begin
        go[NSTAGE] = m_axis_tready;
        for (int i = NSTAGE - 1; i >= 0; i--)
        begin
            go[i] = !valid_reg[i] || go[i+1];
        end
    end

    assign s_axis_tready = go[0];

    // Write beats leave the pipeline once the palette is written
    always_comb
    begin
        valid_next[0] = s_axis_tvalid;
        valid_next[1] = valid_reg[0] && (vtx0_reg == REQ_VERTEX);
        for (int i = 2; i < NSTAGE; i++)
        begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                if (go[i])
                begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    // Split the palette address into bone and word
    assign addr_in    = s_axis_tdata[ADDR_LSB +: ADDR_W];
    assign recip_prod = RECIP_PROD_W'(addr_in) * RECIP_PROD_W'(RECIP_12);
    assign dec_bone   = BONE_W'(recip_prod >> RECIP_SHIFT);
    assign addr_rem   = addr_in - ADDR_W'(dec_bone) * ADDR_W'(WORDS_PER_BONE);
    assign dec_ok     = (PAL_CMP_W'(addr_in) < PAL_CMP_W'(PALETTE_WORDS));

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            vtx0_reg    <= s_axis_tuser;
            pos0_reg[0] <= s_axis_tdata[POS_X_LSB +: COORD_W];
            pos0_reg[1] <= s_axis_tdata[POS_Y_LSB +: COORD_W];
            pos0_reg[2] <= s_axis_tdata[POS_Z_LSB +: COORD_W];
            bones0_reg  <= s_axis_tdata[BONE_SET_LSB +: LANES*BONE_SEL_W];
            for (int k = 0; k < LANES; k++)
            begin
                w0_reg[k] <= s_axis_tdata[WEIGHT_LSB + k*WEIGHT_W +: WEIGHT_W];
            end
            wr_bone0_reg <= dec_bone;
            wr_word0_reg <= addr_rem[WORD_W-1:0];
            wr_ok0_reg   <= dec_ok;
            wr_data0_reg <= s_axis_tdata[VALUE_LSB +: COORD_W];
        end
    end

    // Palette write happens as the write beat leaves stage 0
    assign ctrl.wr_en   = go[1] && valid_reg[0] && (vtx0_reg != REQ_VERTEX) && wr_ok0_reg;
    assign ctrl.wr_bone = wr_bone0_reg;
    assign ctrl.wr_word = wr_word0_reg;
    assign ctrl.wr_data = wr_data0_reg;
    assign ctrl.ld      = go[LANE_STAGES:1];

    // Hold the position next to the palette read
    always_ff @(posedge clk)
    begin
        if (go[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                pos1_reg[r] <= pos0_reg[r];
            end
        end
    end

    genvar k;
    for (k = 0; k < LANES; k++)
    begin : g_lane
        lbs_lane #(
            .NUM_BONES (NUM_BONES)
        ) u_lane (
            .clk     (clk),
            .ctrl    (ctrl),
            .rd_bone (bones0_reg[k*BONE_SEL_W +: BONE_SEL_W]),
            .weight  (w0_reg[k]),
            .pos_x   (pos1_reg[0]),
            .pos_y   (pos1_reg[1]),
            .pos_z   (pos1_reg[2]),
            .term    (term_w[k])
        );
    end

    // Add the weighted terms of all influences
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            acc_next[c] = '0;
            for (int j = 0; j < LANES; j++)
            begin
                acc_next[c] = acc_next[c] + ACC_W'(term_w[j][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[6])
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
    end

    // Drop the weight fraction and clamp into the output register
    always_ff @(posedge clk)
    begin
        if (go[7])
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_reg[c] <= sat32(64'($signed(acc_reg[c][ACC_W-1:FRAC_W])));
            end
        end
    end

    assign m_axis_tvalid = valid_reg[NSTAGE-1];
    assign m_axis_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

endmodule

// File: rtl/core/lbs_lane.sv
module lbs_lane #(
    parameter int NUM_BONES = 64
) (
    input  logic                              clk,
    input  lbs_pkg::lbs_ctrl_t                ctrl,
    input  logic [lbs_pkg::BONE_SEL_W-1:0]    rd_bone,
    input  lbs_pkg::weight_t                  weight,
    input  lbs_pkg::coord_t                   pos_x,
    input  lbs_pkg::coord_t                   pos_y,
    input  lbs_pkg::coord_t                   pos_z,
    output lbs_pkg::term_t                    term [3]
);
    import lbs_pkg::*;

    localparam int AW    = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
    localparam int SUM_W = 2 * COORD_W + 2;
    localparam int T_W   = SUM_W - FRAC_W + 1;

    logic [BONE_W-1:0] rd_bone_ext;
    logic              bone_ok;
    coord_t            word_q [WORDS_PER_BONE];
    coord_t            pos [3];

    logic              ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    weight_t           w1_reg, w2_reg, w3_reg, w4_reg;
    logic signed [2*COORD_W-1:0] prod_reg [3][3];
    coord_t            trans2_reg [3];
    coord_t            trans3_reg [3];
    logic signed [SUM_W-1:0] sum3_reg [3];
    logic signed [T_W-1:0]   t_wide [3];
    coord_t            t_next [3];
    coord_t            t_reg [3];
    term_t             term_reg [3];

    assign rd_bone_ext = BONE_W'(rd_bone);
    assign bone_ok     = ((BONE_W + 1)'(rd_bone_ext) < (BONE_W + 1)'(NUM_BONES));
    assign pos[0]      = pos_x;
    assign pos[1]      = pos_y;
    assign pos[2]      = pos_z;

    // One palette copy per matrix word: write one word, read the whole bone row
    genvar w;
    for (w = 0; w < WORDS_PER_BONE; w++)
    begin : g_word
        coord_t mem [NUM_BONES];
        coord_t rd_reg;

        always_ff @(posedge clk)
        begin
            if (ctrl.wr_en && ctrl.wr_word == WORD_W'(w))
            begin
                mem[ctrl.wr_bone[AW-1:0]] <= ctrl.wr_data;
            end
            if (ctrl.ld[0])
            begin
                rd_reg <= mem[rd_bone_ext[AW-1:0]];
            end
        end

        assign word_q[w] = rd_reg;
    end

    // Carry bone range check and weight beside the palette read
    always_ff @(posedge clk)
    begin
        if (ctrl.ld[0])
        begin
            ok1_reg <= bone_ok;
            w1_reg  <= weight;
        end
    end

    // Multiply each coordinate by its matrix element
    always_ff @(posedge clk)
    begin
        if (ctrl.ld[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    prod_reg[c][r] <= pos[r] * word_q[r*3 + c];
                end
                trans2_reg[c] <= word_q[9 + c];
            end
            ok2_reg <= ok1_reg;
            w2_reg  <= w1_reg;
        end
    end

    // Sum the three products of each column exactly
    always_ff @(posedge clk)
    begin
        if (ctrl.ld[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum3_reg[c] <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                             + SUM_W'(prod_reg[c][2]);
                trans3_reg[c] <= trans2_reg[c];
            end
            ok3_reg <= ok2_reg;
            w3_reg  <= w2_reg;
        end
    end

    // Drop the fraction, add the translation row, clamp
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            t_wide[c] = T_W'($signed(sum3_reg[c][SUM_W-1:FRAC_W])) + T_W'(trans3_reg[c]);
            t_next[c] = sat32(64'(t_wide[c]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                t_reg[c] <= t_next[c];
            end
            ok4_reg <= ok3_reg;
            w4_reg  <= w3_reg;
        end
    end

    // Scale by the weight; a bone outside the palette contributes zero
    always_ff @(posedge clk)
    begin
        if (ctrl.ld[4])
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (ok4_reg)
                begin
                    term_reg[c] <= t_reg[c] * $signed({1'b0, w4_reg});
                end
                else
                begin
                    term_reg[c] <= '0;
                end
            end
        end
    end

    assign term[0] = term_reg[0];
    assign term[1] = term_reg[1];
    assign term[2] = term_reg[2];

endmodule

// File: rtl/core/lbs_checker.sv
module lbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lbs_pkg::*;

    // A stalled output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // With the output free to move, the whole pipeline moves and input is taken
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled although output side is free");

    // A vertex beat reaches the output if m_axis_tready holds while it passes the stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_VERTEX)
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("vertex beat did not reach the output in time");

endmodule

bind linear_blend_vertex_skinning_top lbs_checker u_lbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
